FILE: sv/aub_pkg.sv
`default_nettype none
package aub_pkg;

  localparam int VW     = 32;
  localparam int IDX_W  = 10;
  localparam int STEP_W = 17;
  localparam int CFG_W  = 17;

  localparam logic [STEP_W-1:0] STEP_MAX  = '1;
  localparam logic [24:0]       ONE_TENTH = 25'd6554;

  localparam logic [15:0]       LR_RESET    = 16'd655;
  localparam logic [15:0]       B1_RESET    = 16'd58982;
  localparam logic [15:0]       B2_RESET    = 16'd65470;
  localparam logic [STEP_W-1:0] LIMIT_RESET = 17'd10000;

  typedef enum logic [1:0] {
    CFG_LR    = 2'd0,
    CFG_B1    = 2'd1,
    CFG_B2    = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_GRAD = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [VW-1:0] pos;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] m;
    logic        [VW-1:0] u;
  } elem_t;

endpackage
`default_nettype wire

FILE: sv/aub_in_if.sv
`default_nettype none
interface aub_in_if import aub_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        index;
  logic signed [VW-1:0]    value;
  logic signed [VW-1:0]    lower_bound;
  logic signed [VW-1:0]    upper_bound;
  logic                    last_of_step;

  modport source (output valid, action, index, value, lower_bound, upper_bound,
                  last_of_step, input ready);
  modport sink   (input valid, action, index, value, lower_bound, upper_bound,
                  last_of_step, output ready);
endinterface
`default_nettype wire

FILE: sv/aub_out_if.sv
`default_nettype none
interface aub_out_if import aub_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [VW-1:0]    position;
  logic [STEP_W-1:0]       step_count;
  logic                    limit_reached;

  modport source (output valid, out_index, position, step_count, limit_reached,
                  input ready);
  modport sink   (input valid, out_index, position, step_count, limit_reached,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/aub_ram.sv
`default_nettype none
module aub_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/adam_bounded_update_core.sv
`default_nettype none
// Adam update engine over a stored vector of DIM Q16.16 elements, each with a
// position, box bounds and two moments held in one element RAM. A load word
// writes position and bounds and clears the moments (index 0 also restarts the
// step count and beta powers). A gradient word goes through a RAM read, the
// moment update, then a shared one-bit-per-cycle square root unit (run twice)
// and a shared restoring divider (run twice). One word is worked on at a time;
// a new word is taken while the previous result still waits in the output
// register. Results come out in input order, one per word.
module adam_bounded_update_core import aub_pkg::*; #(
  parameter int DIM = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  aub_in_if.sink                 in_chan,
  aub_out_if.source              out_chan
);
  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int EW = $bits(elem_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_M2, ST_U2, ST_SQU, ST_SQB, ST_RMUL, ST_DIVR,
    ST_PMUL, ST_DIVP, ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0]       lr_r, b1_r, b2_r;
  logic [STEP_W-1:0] limit_r;

  // step state
  logic [STEP_W-1:0] steps_r;
  logic [31:0]       bp1_r, bp2_r;

  // current word
  logic                 act_r, last_r, inside_r;
  logic [IDX_W-1:0]     idx_r;
  logic signed [VW-1:0] val_r, lo_in_r, hi_in_r;

  // element and datapath
  elem_t                el_r;
  logic signed [49:0]   pa_r, pb_r;
  logic [49:0]          ua_r, ub_r;
  logic [31:0]          gsq_r;
  logic [24:0]          d_r;
  logic [31:0]          s2_r;
  logic [31:0]          rate_r;
  logic [51:0]          qd_r;

  // sqrt unit
  logic [63:0] sq_x_r, sq_q_r, sq_bit_r;
  logic [4:0]  sq_cnt_r;
  logic [63:0] sq_t, sq_x_nxt, sq_q_nxt;

  // divider unit
  logic [32:0] dv_rem_r, dv_den_r;
  logic [63:0] dv_quo_r;
  logic [5:0]  dv_cnt_r;
  logic [33:0] dv_sh;
  logic        dv_ge;
  logic [32:0] dv_rem_nxt;
  logic [63:0] dv_quo_nxt;

  // RAM
  elem_t          rd_el, wr_el;
  logic [EW-1:0]  ram_rdata;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;

  // output register
  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_index_r;
  logic signed [VW-1:0] out_pos_r;
  logic [STEP_W-1:0]    out_steps_r;
  logic                 out_limit_r;

  logic             accept;
  logic             fin_go;
  logic [16:0]      in_idx_ext;
  logic             in_inside;
  logic [31:0]      mag_g;
  logic [47:0]      g_sq;
  logic [31:0]      gsq_now;
  logic [49:0]      m_sum, u_sum;
  logic [31:0]      u_new;
  logic [32:0]      q1, q2;
  logic [31:0]      mag_m;
  logic [53:0]      x_base, x_delta, x_sum, x_clamp;
  logic [53:0]      lo_ext, hi_ext;
  logic [48:0]      bp1_prod, bp2_prod;
  logic [STEP_W-1:0] steps_nxt;
  logic [31:0]      bp1_nxt, bp2_nxt;
  logic [51:0]      qd_round;

  assign accept    = (state_r == ST_IDLE) && in_chan.valid;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  assign in_idx_ext = {{(17-IDX_W){1'b0}}, in_chan.index};
  assign in_inside  = in_idx_ext < 17'(DIM);

  assign rd_el     = elem_t'(ram_rdata);
  assign ram_raddr = AW'(in_idx_ext);
  assign ram_waddr = AW'({{(17-IDX_W){1'b0}}, idx_r});

  aub_ram #(.WIDTH(EW), .DEPTH(DIM)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_el),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // square root step
  always_comb begin
    sq_t = sq_q_r + sq_bit_r;
    if (sq_x_r >= sq_t) begin
      sq_x_nxt = sq_x_r - sq_t;
      sq_q_nxt = (sq_q_r >> 1) + sq_bit_r;
    end else begin
      sq_x_nxt = sq_x_r;
      sq_q_nxt = sq_q_r >> 1;
    end
  end

  // restoring divide step
  assign dv_sh      = {dv_rem_r, dv_quo_r[63]};
  assign dv_ge      = dv_sh >= {1'b0, dv_den_r};
  assign dv_rem_nxt = dv_ge ? 33'(dv_sh - {1'b0, dv_den_r}) : dv_sh[32:0];
  assign dv_quo_nxt = {dv_quo_r[62:0], dv_ge};
  assign qd_round   = dv_quo_nxt[51:0] +
                      52'({dv_rem_nxt, 1'b0} >= {1'b0, dv_den_r});

  // gradient square, saturating
  assign mag_g   = val_r[31] ? 32'(~val_r + 32'sd1) : 32'(val_r);
  assign g_sq    = mag_g[23:0] * mag_g[23:0];
  assign gsq_now = (mag_g[31:24] != 8'd0) ? 32'hFFFF_FFFF
                 : 32'((49'(g_sq) + 49'd32768) >> 16);

  assign m_sum = 50'(pa_r + pb_r + 50'sd32768);
  assign u_sum = ua_r + ub_r + 50'd32768;
  assign u_new = u_sum[47:16];

  assign q1 = 33'h1_0000_0000 - {1'b0, bp1_r};
  assign q2 = 33'h1_0000_0000 - {1'b0, bp2_r};

  assign mag_m = el_r.m[31] ? 32'(~el_r.m + 32'sd1) : 32'(el_r.m);

  // position update and clamp
  assign x_base  = 54'(el_r.pos);
  assign x_delta = el_r.m[31] ? 54'(-$signed({2'b00, qd_r})) : {2'b00, qd_r};
  assign x_sum   = x_base - x_delta;
  assign lo_ext  = 54'(el_r.lo);
  assign hi_ext  = 54'(el_r.hi);
  always_comb begin
    x_clamp = x_sum;
    if ($signed(x_clamp) > $signed(hi_ext)) x_clamp = hi_ext;
    if ($signed(x_clamp) < $signed(lo_ext)) x_clamp = lo_ext;
  end

  assign bp1_prod = 49'(bp1_r * b1_r) + 49'd32768;
  assign bp2_prod = 49'(bp2_r * b2_r) + 49'd32768;

  always_comb begin
    steps_nxt = steps_r;
    bp1_nxt   = bp1_r;
    bp2_nxt   = bp2_r;
    if (act_r == ACT_LOAD) begin
      if (idx_r == '0) begin
        steps_nxt = '0;
        bp1_nxt   = {b1_r, 16'd0};
        bp2_nxt   = {b2_r, 16'd0};
      end
    end else if (last_r) begin
      if (steps_r != STEP_MAX) steps_nxt = steps_r + 1'b1;
      bp1_nxt = bp1_prod[47:16];
      bp2_nxt = bp2_prod[47:16];
    end
  end

  always_comb begin
    ram_we = fin_go && inside_r;
    if (act_r == ACT_LOAD) begin
      wr_el = '{pos: val_r, lo: lo_in_r, hi: hi_in_r, m: '0, u: '0};
    end else begin
      wr_el = '{pos: x_clamp[31:0], lo: el_r.lo, hi: el_r.hi, m: el_r.m, u: el_r.u};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lr_r        <= LR_RESET;
      b1_r        <= B1_RESET;
      b2_r        <= B2_RESET;
      limit_r     <= LIMIT_RESET;
      steps_r     <= '0;
      bp1_r       <= {B1_RESET, 16'd0};
      bp2_r       <= {B2_RESET, 16'd0};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LR:    lr_r    <= cfg_data[15:0];
          CFG_B1:    b1_r    <= cfg_data[15:0];
          CFG_B2:    b2_r    <= cfg_data[15:0];
          CFG_LIMIT: limit_r <= cfg_data;
          default:   ;
        endcase
      end

      if (out_valid_r && out_chan.ready && !fin_go) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            act_r    <= in_chan.action;
            idx_r    <= in_chan.index;
            val_r    <= in_chan.value;
            lo_in_r  <= in_chan.lower_bound;
            hi_in_r  <= in_chan.upper_bound;
            last_r   <= in_chan.last_of_step;
            inside_r <= in_inside;
            if (in_chan.action == ACT_GRAD && in_inside) state_r <= ST_RD;
            else state_r <= ST_FIN;
          end
        end
        ST_RD: begin
          el_r  <= rd_el;
          pa_r  <= 50'($signed({1'b0, b1_r}) * rd_el.m);
          pb_r  <= 50'($signed(18'h1_0000 - {2'b00, b1_r}) * val_r);
          gsq_r <= gsq_now;
          state_r <= ST_M2;
        end
        ST_M2: begin
          el_r.m <= m_sum[47:16];
          ua_r   <= 50'(b2_r * el_r.u);
          ub_r   <= 50'((17'h1_0000 - {1'b0, b2_r}) * gsq_r);
          state_r <= ST_U2;
        end
        ST_U2: begin
          el_r.u   <= u_new;
          sq_x_r   <= {u_new, 16'd0};
          sq_q_r   <= '0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
          sq_cnt_r <= '0;
          state_r  <= ST_SQU;
        end
        ST_SQU: begin
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'd31) begin
            d_r      <= 25'(sq_q_nxt[23:0]) + ONE_TENTH;
            sq_x_r   <= 64'({q2, 30'd0});
            sq_q_r   <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            state_r  <= ST_SQB;
          end else begin
            sq_x_r   <= sq_x_nxt;
            sq_q_r   <= sq_q_nxt;
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        ST_SQB: begin
          sq_x_r   <= sq_x_nxt;
          sq_q_r   <= sq_q_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'd31) begin
            s2_r    <= sq_q_nxt[31:0];
            state_r <= ST_RMUL;
          end
        end
        ST_RMUL: begin
          // lr * s2 * 2 + q1/2, rounded divide by q1
          dv_quo_r <= 64'({48'(lr_r * s2_r), 1'b0}) + 64'(q1 >> 1);
          dv_den_r <= q1;
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
          state_r  <= ST_DIVR;
        end
        ST_DIVR: begin
          dv_rem_r <= dv_rem_nxt;
          dv_quo_r <= dv_quo_nxt;
          dv_cnt_r <= dv_cnt_r + 1'b1;
          if (dv_cnt_r == 6'd63) begin
            rate_r  <= (dv_quo_nxt[63:32] != '0) ? 32'hFFFF_FFFF : dv_quo_nxt[31:0];
            state_r <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          dv_quo_r <= rate_r * mag_m;
          dv_den_r <= 33'(d_r);
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
          state_r  <= ST_DIVP;
        end
        ST_DIVP: begin
          dv_rem_r <= dv_rem_nxt;
          dv_quo_r <= dv_quo_nxt;
          dv_cnt_r <= dv_cnt_r + 1'b1;
          if (dv_cnt_r == 6'd63) begin
            qd_r    <= qd_round;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            steps_r     <= steps_nxt;
            bp1_r       <= bp1_nxt;
            bp2_r       <= bp2_nxt;
            out_valid_r <= 1'b1;
            out_index_r <= idx_r;
            out_steps_r <= steps_nxt;
            out_limit_r <= steps_nxt >= limit_r;
            if (!inside_r) out_pos_r <= '0;
            else if (act_r == ACT_LOAD) out_pos_r <= val_r;
            else out_pos_r <= x_clamp[31:0];
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_index     = out_index_r;
  assign out_chan.position      = out_pos_r;
  assign out_chan.step_count    = out_steps_r;
  assign out_chan.limit_reached = out_limit_r;

endmodule
`default_nettype wire
